// ----- rtl/forth_word_tokenizer_hash_unit_assert.svh -----
// Assertion macros used by the tokenizer scanner RTL.
`ifndef FORTH_WORD_TOKENIZER_HASH_UNIT_ASSERT_SVH
`define FORTH_WORD_TOKENIZER_HASH_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// Clocked check, disabled while reset is asserted
`define FWTH_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("tokenizer check failed");
// Clocked check that also holds during reset
`define FWTH_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("tokenizer check failed");
`else
`define FWTH_ASSERT(lbl, prop)
`define FWTH_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// ----- rtl/fwth_pkg.sv -----
// Types and constants of the word tokenizer.
`default_nettype none
package fwth_pkg;

  localparam logic [7:0] CharZero   = 8'h00;
  localparam logic [7:0] CharSpace  = 8'h20;
  localparam logic [7:0] CharTab    = 8'h09;
  localparam logic [7:0] CharCr     = 8'h0d;
  localparam logic [7:0] CharLf     = 8'h0a;
  localparam logic [7:0] CharLParen = 8'h28;
  localparam logic [7:0] CharRParen = 8'h29;
  localparam logic [7:0] CharBslash = 8'h5c;
  localparam logic [7:0] CharLowA   = 8'h61;
  localparam logic [7:0] CharLowZ   = 8'h7a;
  localparam logic [7:0] CaseDelta  = 8'h20;
  localparam int unsigned BucketW   = 6;

  typedef enum logic [1:0] {
    MODE_BETWEEN = 2'd0,
    MODE_WORD    = 2'd1,
    MODE_PAREN   = 2'd2,
    MODE_LINE    = 2'd3
  } scan_mode_e;

  // Decoded view of one text byte
  typedef struct packed {
    logic       is_zero;
    logic       is_sep;
    logic       is_eol;
    logic       is_rparen;
    logic [7:0] upper;
  } char_class_t;

  // One emitted token character
  typedef struct packed {
    logic               has_char;
    logic [7:0]         token_char;
    logic               first_of_word;
    logic               last_of_word;
    logic [BucketW-1:0] bucket;
    logic               text_end;
  } token_t;

endpackage
`default_nettype wire

// ----- rtl/fwth_classify.sv -----
// Byte classifier: separators, line ends, terminator, comment close and uppercase.
`default_nettype none
module fwth_classify (
  input  logic [7:0]           text_char_i,
  output fwth_pkg::char_class_t cls_o
);
  import fwth_pkg::*;

  // Decode the byte
  always_comb begin
    cls_o.is_zero   = (text_char_i == CharZero);
    cls_o.is_sep    = text_char_i inside {CharSpace, CharTab, CharCr, CharLf};
    cls_o.is_eol    = text_char_i inside {CharCr, CharLf};
    cls_o.is_rparen = (text_char_i == CharRParen);
    if (text_char_i inside {[CharLowA:CharLowZ]}) begin
      cls_o.upper = text_char_i - CaseDelta;
    end else begin
      cls_o.upper = text_char_i;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/fwth_scan.sv -----
// Scanner state machine: word tracking, comment skipping and hash sum.
`default_nettype none
module fwth_scan #(
  parameter int unsigned TOKEN_MAX   = 254,
  parameter int unsigned NUM_BUCKETS = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  advance_i,
  input  fwth_pkg::char_class_t cls_i,
  output logic                  res_valid_o,
  output fwth_pkg::token_t      res_o
);
  import fwth_pkg::*;

  localparam int unsigned LenW  = $clog2(TOKEN_MAX + 1);
  localparam int unsigned HashW = $clog2(NUM_BUCKETS);

  // Residue of every byte value, worked out at elaboration
  function automatic logic [255:0][HashW-1:0] build_mod_tbl();
    logic [255:0][HashW-1:0] t;
    for (int i = 0; i < 256; i++) begin
      t[i] = HashW'(i % NUM_BUCKETS);
    end
    return t;
  endfunction

  localparam logic [255:0][HashW-1:0] ModTbl = build_mod_tbl();

  scan_mode_e        mode_q, mode_d;
  logic [7:0]        held_q, held_d;
  logic [LenW-1:0]   len_q, len_d;
  logic [HashW-1:0]  hash_q, hash_d;
  logic              first_q, first_d;

  logic [HashW-1:0]  char_mod;
  logic [HashW:0]    sum_raw;
  logic [HashW-1:0]  hash_add;
  logic              lone_comment;
  logic              last;

  // Add the new byte to the running sum, one conditional subtract
  assign char_mod = ModTbl[cls_i.upper];
  assign sum_raw  = {1'b0, hash_q} + {1'b0, char_mod};
  assign hash_add = (sum_raw >= (HashW+1)'(NUM_BUCKETS))
                    ? HashW'(sum_raw - (HashW+1)'(NUM_BUCKETS)) : HashW'(sum_raw);

  assign lone_comment = (len_q == LenW'(1)) && (cls_i.is_zero || cls_i.is_sep) &&
                        ((held_q == CharLParen) || (held_q == CharBslash));
  assign last = cls_i.is_zero || cls_i.is_sep || (len_q >= LenW'(TOKEN_MAX));

  // Hold state until an item is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_BETWEEN;
      held_q  <= '0;
      len_q   <= '0;
      hash_q  <= '0;
      first_q <= 1'b1;
    end else if (advance_i) begin
      mode_q  <= mode_d;
      held_q  <= held_d;
      len_q   <= len_d;
      hash_q  <= hash_d;
      first_q <= first_d;
    end
  end

  // Next state and result
  always_comb begin
    mode_d      = mode_q;
    held_d      = held_q;
    len_d       = len_q;
    hash_d      = hash_q;
    first_d     = first_q;
    res_valid_o = 1'b0;
    res_o       = '0;

    case (mode_q)
      MODE_WORD: begin
        if (lone_comment) begin
          // Drop the comment word and enter the skip mode
          held_d  = '0;
          len_d   = '0;
          hash_d  = '0;
          first_d = 1'b1;
          if (cls_i.is_zero) begin
            mode_d         = MODE_BETWEEN;
            res_valid_o    = 1'b1;
            res_o.text_end = 1'b1;
          end else if (held_q == CharLParen) begin
            mode_d = MODE_PAREN;
          end else if (cls_i.is_eol) begin
            mode_d = MODE_BETWEEN;
          end else begin
            mode_d = MODE_LINE;
          end
        end else begin
          // Emit the held character
          res_valid_o         = 1'b1;
          res_o.has_char      = 1'b1;
          res_o.token_char    = held_q;
          res_o.first_of_word = first_q;
          res_o.last_of_word  = last;
          res_o.bucket        = last ? BucketW'(hash_q) : '0;
          res_o.text_end      = cls_i.is_zero;
          if (cls_i.is_zero || cls_i.is_sep) begin
            mode_d  = MODE_BETWEEN;
            held_d  = '0;
            len_d   = '0;
            hash_d  = '0;
            first_d = 1'b1;
          end else if (last) begin
            // Cut word: this byte opens a new one
            held_d  = cls_i.upper;
            len_d   = LenW'(1);
            hash_d  = char_mod;
            first_d = 1'b1;
          end else begin
            held_d  = cls_i.upper;
            len_d   = len_q + LenW'(1);
            hash_d  = hash_add;
            first_d = 1'b0;
          end
        end
      end
      MODE_PAREN: begin
        if (cls_i.is_rparen) begin
          mode_d = MODE_BETWEEN;
        end
      end
      MODE_LINE: begin
        if (cls_i.is_eol) begin
          mode_d = MODE_BETWEEN;
        end
      end
      default: begin
        if (!cls_i.is_sep && !cls_i.is_zero) begin
          mode_d  = MODE_WORD;
          held_d  = cls_i.upper;
          len_d   = LenW'(1);
          hash_d  = char_mod;
          first_d = 1'b1;
        end
      end
    endcase

    // Terminator outside a word ends the text
    if ((mode_q != MODE_WORD) && cls_i.is_zero) begin
      mode_d         = MODE_BETWEEN;
      res_valid_o    = 1'b1;
      res_o.text_end = 1'b1;
    end
  end

`include "forth_word_tokenizer_hash_unit_assert.svh"

  `FWTH_ASSERT(a_len_bound, len_q <= LenW'(TOKEN_MAX))
  `FWTH_ASSERT(a_idle_clear, (mode_q != MODE_WORD) |-> (len_q == '0) && (hash_q == '0))
  `FWTH_ASSERT(a_word_len, (mode_q == MODE_WORD) |-> (len_q != '0))
  `FWTH_ASSERT(a_end_reset, (advance_i && cls_i.is_zero) |=> (mode_q == MODE_BETWEEN) && first_q)

endmodule
`default_nettype wire

// ----- rtl/fwth_out_reg.sv -----
// Result register between the scanner and the output channel.
`default_nettype none
module fwth_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  fwth_pkg::token_t res_i,
  output logic             free_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output fwth_pkg::token_t res_o
);
  import fwth_pkg::*;

  logic   valid_q;
  token_t res_q;

  // Room for a new result when empty or draining this cycle
  assign free_o      = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign res_o       = res_q;

  // Track occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  // Capture the payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/forth_word_tokenizer_hash_unit.sv -----
// Top level of the whitespace word tokenizer with hash bucket.
//
//  channel | handshake                 | payload
//  --------+---------------------------+------------------------------------------
//  input   | in_valid_i / in_ready_o   | text_char_i
//  output  | out_valid_o / out_ready_i | has_char_o token_char_o first_of_word_o
//          |                           | last_of_word_o bucket_o text_end_o
//
// One byte per cycle while in_ready_o is high; the result it causes is in the output register in the next cycle.
// Each byte is one pass through the classifier and the scanner into that register.
// in_ready_o drops only while the output register holds a result that is not taken.
// Reset brings the scanner to the between-words state; no clearing pass.
`default_nettype none
module forth_word_tokenizer_hash_unit #(
  parameter int unsigned TOKEN_MAX   = 254,
  parameter int unsigned NUM_BUCKETS = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    text_char_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          has_char_o,
  output logic [7:0]                    token_char_o,
  output logic                          first_of_word_o,
  output logic                          last_of_word_o,
  output logic [fwth_pkg::BucketW-1:0]  bucket_o,
  output logic                          text_end_o
);
  import fwth_pkg::*;

  char_class_t cls;
  logic        advance;
  logic        res_valid;
  logic        free;
  token_t      res;
  token_t      out_res;

  assign in_ready_o = free;
  assign advance    = in_valid_i && in_ready_o;

  fwth_classify u_classify (
    .text_char_i (text_char_i),
    .cls_o       (cls)
  );

  fwth_scan #(
    .TOKEN_MAX   (TOKEN_MAX),
    .NUM_BUCKETS (NUM_BUCKETS)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (advance),
    .cls_i       (cls),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  fwth_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance && res_valid),
    .res_i       (res),
    .free_o      (free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (out_res)
  );

  // Unpack the result onto the ports
  assign has_char_o      = out_res.has_char;
  assign token_char_o    = out_res.token_char;
  assign first_of_word_o = out_res.first_of_word;
  assign last_of_word_o  = out_res.last_of_word;
  assign bucket_o        = out_res.bucket;
  assign text_end_o      = out_res.text_end;

endmodule
`default_nettype wire

// ----- sim/tb_forth_word_tokenizer_hash_unit.sv -----
// Self-checking testbench for the whitespace word tokenizer with hash bucket.
`timescale 1ns / 1ps
module tb_forth_word_tokenizer_hash_unit;
  import fwth_pkg::*;

  localparam int unsigned TOKEN_MAX   = 254;
  localparam int unsigned NUM_BUCKETS = 64;
  localparam int          TEXT_ITEMS  = 2000;
  localparam int          HOLD_CYCLES = 60;

  typedef enum {FLOW_FREE, FLOW_SEND_GAPS, FLOW_RECV_STALLS, FLOW_BOTH} flow_e;

  // One row of the directed script: byte to send, and optionally the token it must yield
  typedef struct packed {
    logic [7:0] ch;
    logic       typed;
    token_t     tok;
  } script_row_t;

  localparam token_t NO_TOKEN = '0;
  localparam token_t END_ONLY = {1'b0, 8'h00, 1'b0, 1'b0, 6'd0, 1'b1};

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic [7:0]          text_char = 8'h00;
  logic                out_ready = 1'b0;
  logic                in_ready;
  logic                out_valid;
  logic                has_char;
  logic [7:0]          token_char;
  logic                first_of_word;
  logic                last_of_word;
  logic [BucketW-1:0]  bucket;
  logic                text_end;

  flow_e  flow = FLOW_FREE;
  token_t expected_tokens[$];
  int     text_items       = 0;
  int     tokens_seen      = 0;
  int     ends_seen        = 0;
  int     mismatches       = 0;
  int     words_cut        = 0;
  int     comments_skipped = 0;
  int     hold_asked       = 0;
  int     hold_given       = 0;
  int     hold_left        = 0;

  // Scanner state of the predictor
  scan_mode_e  scan_state;
  logic [7:0]  held_byte;
  logic        held_ok;
  logic [7:0]  word_len;
  int unsigned hash_acc;
  logic        first_next;

  script_row_t script [27] = '{
    {CharZero,   1'b1, END_ONLY},
    {CharLowA,   1'b0, NO_TOKEN},
    {CharLowZ,   1'b1, token_t'({1'b1, 8'h41, 1'b1, 1'b0, 6'd0, 1'b0})},
    {CharSpace,  1'b1, token_t'({1'b1, 8'h5a, 1'b0, 1'b1, 6'd27, 1'b0})},
    {CharLParen, 1'b0, NO_TOKEN},
    {8'h78,      1'b0, NO_TOKEN},
    {CharTab,    1'b0, NO_TOKEN},
    {CharLParen, 1'b0, NO_TOKEN},
    {CharSpace,  1'b0, NO_TOKEN},
    {8'h71,      1'b0, NO_TOKEN},
    {CharRParen, 1'b0, NO_TOKEN},
    {CharBslash, 1'b0, NO_TOKEN},
    {CharSpace,  1'b0, NO_TOKEN},
    {8'h77,      1'b0, NO_TOKEN},
    {CharCr,     1'b0, NO_TOKEN},
    {CharBslash, 1'b0, NO_TOKEN},
    {CharLf,     1'b0, NO_TOKEN},
    {8'hff,      1'b0, NO_TOKEN},
    {8'h80,      1'b1, token_t'({1'b1, 8'hff, 1'b1, 1'b0, 6'd0, 1'b0})},
    {CharZero,   1'b1, token_t'({1'b1, 8'h80, 1'b0, 1'b1, 6'd63, 1'b1})},
    {CharLParen, 1'b0, NO_TOKEN},
    {CharZero,   1'b1, END_ONLY},
    {CharLParen, 1'b0, NO_TOKEN},
    {CharSpace,  1'b0, NO_TOKEN},
    {CharZero,   1'b1, END_ONLY},
    {8'h01,      1'b0, NO_TOKEN},
    {CharZero,   1'b1, token_t'({1'b1, 8'h01, 1'b1, 1'b1, 6'd1, 1'b1})}
  };

  forth_word_tokenizer_hash_unit #(
    .TOKEN_MAX(TOKEN_MAX),
    .NUM_BUCKETS(NUM_BUCKETS)
  ) dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .text_char_i    (text_char),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .has_char_o     (has_char),
    .token_char_o   (token_char),
    .first_of_word_o(first_of_word),
    .last_of_word_o (last_of_word),
    .bucket_o       (bucket),
    .text_end_o     (text_end)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic bit is_blank(logic [7:0] c);
    return c == CharSpace || c == CharTab || c == CharCr || c == CharLf;
  endfunction

  function automatic logic [7:0] fold_case(logic [7:0] c);
    return (c >= CharLowA && c <= CharLowZ) ? c - CaseDelta : c;
  endfunction

  function automatic void clear_scan();
    scan_state = MODE_BETWEEN;
    held_byte  = 8'h00;
    held_ok    = 1'b0;
    word_len   = 8'd0;
    hash_acc   = 0;
    first_next = 1'b1;
  endfunction

  function automatic void begin_word(logic [7:0] c);
    scan_state = MODE_WORD;
    held_byte  = fold_case(c);
    held_ok    = 1'b1;
    first_next = 1'b1;
    word_len   = 8'd1;
    hash_acc   = held_byte % NUM_BUCKETS;
  endfunction

  // Advance the scanner by one byte; return 1 when the byte yields a token
  function automatic bit tokenize_byte(input logic [7:0] c, output token_t tok);
    bit blank;
    bit last;
    blank = is_blank(c);
    tok   = '0;
    if (scan_state != MODE_WORD || !held_ok) begin
      if (c == CharZero) begin
        clear_scan();
        tok.text_end = 1'b1;
        return 1'b1;
      end
      case (scan_state)
        MODE_PAREN: if (c == CharRParen) scan_state = MODE_BETWEEN;
        MODE_LINE:  if (c == CharCr || c == CharLf) scan_state = MODE_BETWEEN;
        default: begin
          if (!blank) begin_word(c);
          else scan_state = MODE_BETWEEN;
        end
      endcase
      return 1'b0;
    end
    // lone comment word: swallow it and start skipping
    if (word_len == 8'd1 && (c == CharZero || blank) &&
        (held_byte == CharLParen || held_byte == CharBslash)) begin
      if (c == CharZero) begin
        clear_scan();
        tok.text_end = 1'b1;
        return 1'b1;
      end
      comments_skipped++;
      if (held_byte == CharLParen) scan_state = MODE_PAREN;
      else if (c == CharCr || c == CharLf) scan_state = MODE_BETWEEN;
      else scan_state = MODE_LINE;
      held_ok    = 1'b0;
      held_byte  = 8'h00;
      word_len   = 8'd0;
      hash_acc   = 0;
      first_next = 1'b1;
      return 1'b0;
    end
    last = (c == CharZero) || blank || (word_len >= TOKEN_MAX);
    tok.has_char      = 1'b1;
    tok.token_char    = held_byte;
    tok.first_of_word = first_next;
    tok.last_of_word  = last;
    tok.bucket        = last ? hash_acc[BucketW-1:0] : '0;
    tok.text_end      = (c == CharZero);
    if (c == CharZero || blank) begin
      clear_scan();
    end else if (last) begin
      words_cut++;
      begin_word(c);
    end else begin
      held_byte  = fold_case(c);
      first_next = 1'b0;
      word_len   = word_len + 8'd1;
      hash_acc   = (hash_acc + held_byte) % NUM_BUCKETS;
    end
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------- stimulus

  // Offer one byte, hold it until taken, then record what it must produce
  task automatic send_char(input logic [7:0] c, input bit typed = 1'b0,
                           input token_t typed_tok = '0);
    token_t tok;
    bit     produced;
    bit     in_comment;
    while ((flow == FLOW_SEND_GAPS && $urandom_range(99) < 87) ||
           (flow == FLOW_BOTH && $urandom_range(99) < 27)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    text_char <= c;
    do @(posedge clk); while (!in_ready);
    in_comment = (scan_state == MODE_PAREN) || (scan_state == MODE_LINE);
    produced   = tokenize_byte(c, tok);
    if (produced) expected_tokens.push_back(typed ? typed_tok : tok);
    if (!in_comment) text_items++;
  endtask

  function automatic logic [7:0] word_byte();
    logic [7:0] c;
    case ($urandom_range(3))
      0:       c = 8'($urandom_range(8'h61, 8'h7a));
      1:       c = 8'($urandom_range(8'h41, 8'h5a));
      2:       c = 8'($urandom_range(8'h21, 8'h7e));
      default: c = 8'($urandom_range(1, 255));
    endcase
    if (is_blank(c)) c = 8'h5f;
    return c;
  endfunction

  function automatic logic [7:0] blank_byte();
    case ($urandom_range(3))
      0:       return CharSpace;
      1:       return CharTab;
      2:       return CharCr;
      default: return CharLf;
    endcase
  endfunction

  // Word around or past the cut length, optionally followed by a lone comment word
  task automatic send_long_word(input int len, input bit lone_tail);
    repeat (len) send_char(word_byte());
    if (lone_tail) begin
      send_char($urandom_range(1) ? CharLParen : CharBslash);
      send_char(CharSpace);
      send_char(8'h2e);
      send_char(CharRParen);
      send_char(CharLf);
    end else begin
      send_char(blank_byte());
    end
  endtask

  initial begin : stimulus
    int         pick;
    int         len;
    logic [7:0] c;
    clear_scan();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // walk the directed script
    foreach (script[i]) send_char(script[i].ch, script[i].typed, script[i].tok);

    // hold the receiver off while full-length words pour in
    hold_asked++;
    send_long_word(TOKEN_MAX, 1'b1);
    send_long_word(TOKEN_MAX + 1, 1'b0);

    while (text_items < TEXT_ITEMS) begin
      case (text_items * 4 / TEXT_ITEMS)
        0:       flow = FLOW_FREE;
        1:       flow = FLOW_SEND_GAPS;
        2:       flow = FLOW_RECV_STALLS;
        default: flow = FLOW_BOTH;
      endcase
      pick = $urandom_range(999);
      if (pick < 6) begin
        len = ($urandom_range(3) == 0) ? 2 * TOKEN_MAX + 1 : TOKEN_MAX - 1 + $urandom_range(3);
        send_long_word(len, 1'($urandom_range(1)));
      end else if (pick < 60) begin
        send_char(CharZero);
      end else if (pick < 120) begin
        // raw noise over the full byte range
        repeat ($urandom_range(1, 6)) send_char(8'($urandom_range(255)));
      end else if (pick < 220) begin
        send_char(CharLParen);
        send_char(blank_byte());
        repeat ($urandom_range(8)) begin
          c = 8'($urandom_range(1, 255));
          send_char(c == CharRParen ? 8'h2a : c);
        end
        if ($urandom_range(7) == 0) begin
          send_char(CharZero);
        end else begin
          send_char(CharRParen);
          send_char(blank_byte());
        end
      end else if (pick < 300) begin
        send_char(CharBslash);
        if ($urandom_range(3) == 0) begin
          send_char($urandom_range(1) ? CharCr : CharLf);
        end else begin
          send_char($urandom_range(1) ? CharSpace : CharTab);
          repeat ($urandom_range(8)) begin
            c = 8'($urandom_range(1, 255));
            send_char((c == CharCr || c == CharLf) ? 8'h2d : c);
          end
          send_char($urandom_range(1) ? CharCr : CharLf);
        end
      end else begin
        len = ($urandom_range(3) == 0) ? $urandom_range(1, 24) : $urandom_range(1, 6);
        repeat (len) send_char(word_byte());
        send_char(($urandom_range(9) == 0) ? CharZero : blank_byte());
      end
    end
    in_valid <= 1'b0;

    // drain, then keep watching the output for stray tokens
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("text bytes counted: %0d, tokens checked: %0d, text ends: %0d",
             text_items, tokens_seen, ends_seen);
    $display("words cut at %0d chars: %0d, comments skipped: %0d, mismatches: %0d",
             TOKEN_MAX, words_cut, comments_skipped, mismatches);
    if (mismatches == 0) begin
      $display("[forth_word_tokenizer_hash_unit] OK");
    end else begin
      $display("[forth_word_tokenizer_hash_unit] ERROR");
    end
    $finish;
  end

  // ---------------------------------------------------------------- receiver

  // Drive out_ready per flow phase; a requested hold-off overrides it
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_asked != hold_given) begin
      out_ready  <= 1'b0;
      hold_given <= hold_given + 1;
      hold_left  <= HOLD_CYCLES - 1;
    end else begin
      case (flow)
        FLOW_RECV_STALLS: out_ready <= ($urandom_range(99) >= 87);
        FLOW_BOTH:        out_ready <= ($urandom_range(99) >= 27);
        default:          out_ready <= 1'b1;
      endcase
    end
  end

  function automatic string show_tok(token_t t);
    return $sformatf("has=%0b char=%02h first=%0b last=%0b bucket=%0d end=%0b",
                     t.has_char, t.token_char, t.first_of_word, t.last_of_word,
                     t.bucket, t.text_end);
  endfunction

  task automatic log_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endtask

  // Compare each taken token with the oldest expectation
  always @(posedge clk) begin : token_check
    token_t got;
    token_t want;
    if (rst_n && out_valid && out_ready) begin
      got = {has_char, token_char, first_of_word, last_of_word, bucket, text_end};
      tokens_seen++;
      if (got.text_end === 1'b1) ends_seen++;
      if (expected_tokens.size() == 0) begin
        log_mismatch($sformatf("unexpected token: got %s", show_tok(got)));
      end else begin
        want = expected_tokens.pop_front();
        if (got !== want)
          log_mismatch($sformatf("token %0d: expected %s, got %s",
                                 tokens_seen, show_tok(want), show_tok(got)));
      end
    end
  end

  // Stop a hung run
  initial begin
    #10ms;
    $display("[forth_word_tokenizer_hash_unit] ERROR");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/fwth_pkg.sv
rtl/fwth_classify.sv
rtl/fwth_scan.sv
rtl/fwth_out_reg.sv
rtl/forth_word_tokenizer_hash_unit.sv
sim/tb_forth_word_tokenizer_hash_unit.sv
